FILE: rtl/pcsh_pkg.sv
// Shared types and codes of the PC sample histogram.
// Depends on nothing; used by pcsh_map and pc_sample_histogram.
package pcsh_pkg;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_RANGE   = 2'd1,
    ST_OFF     = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  localparam logic FUNC_BILL = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [1:0] REG_PROF_ON  = 2'd0;
  localparam logic [1:0] REG_PC_LOW   = 2'd1;
  localparam logic [1:0] REG_PC_SCALE = 2'd2;
  localparam logic [1:0] REG_BKT_CNT  = 2'd3;

  localparam logic [16:0] SCALE_RESET = 17'd65536;
  localparam logic [12:0] BKT_RESET   = 13'd4096;

  // One request on its way to the counter memory
  typedef struct packed {
    logic        vld;
    status_t     status;
    logic        acc;     // touches the counter memory
    logic        wr;      // writes back the sum
    logic [15:0] addr;
    logic [11:0] bucket;
    logic [15:0] ticks;
  } pipe_t;

endpackage

FILE: rtl/pc_sample_histogram.sv
// Top level of the PC sample histogram: configuration registers, counter
// memory with read-modify-write and forwarding, result register.
// Depends on pcsh_pkg and pcsh_map.

// Takes one request per cycle while no result waits and the clearing sweep is
// over. out_valid rises once a request has passed three mapping stages, of
// which the first loads at the accepting edge, then the counter memory read,
// then the result register. Back-to-back bills to the same bucket are
// forwarded from the last write-back. After reset the counter memory is swept
// to zero, one entry per cycle, over all BUCKETS entries; in_ready stays low
// during the sweep while configuration writes are taken as usual. Either
// side may stall: the pipeline holds as a whole while a result waits.
module pc_sample_histogram #(
  parameter int BUCKETS = 4096,
  parameter int PC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [PC_BITS-1:0] in_pc,
  input  logic [15:0]        in_ticks,
  input  logic [11:0]        in_read_index,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [11:0]        out_bucket,
  output logic [15:0]        out_count,

  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import pcsh_pkg::*;

  localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  logic          prof_on_r;
  logic [31:0]   pc_low_r;
  logic [16:0]   pc_scale_r;
  logic [12:0]   bkt_cnt_r;
  logic          cfg_wr;

  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  logic          adv, take;
  pipe_t         c_req, d_r;

  logic [15:0]   mem [BUCKETS];
  logic [15:0]   mem_q_r;

  logic          fw_vld_r;
  logic [AW-1:0] fw_addr_r;
  logic [15:0]   fw_data_r;

  logic [AW-1:0] d_addr;
  logic [15:0]   rdata, sum;
  logic          wr_en;

  logic          out_vld_r;
  status_t       out_status_r;
  logic [11:0]   out_bucket_r;
  logic [15:0]   out_count_r;

  // Configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_on_r  <= 1'b0;
      pc_low_r   <= 32'd0;
      pc_scale_r <= SCALE_RESET;
      bkt_cnt_r  <= BKT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_PROF_ON:  prof_on_r  <= cfg_pwdata[0];
        REG_PC_LOW:   pc_low_r   <= cfg_pwdata;
        REG_PC_SCALE: pc_scale_r <= cfg_pwdata[16:0];
        REG_BKT_CNT:  bkt_cnt_r  <= cfg_pwdata[12:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_PROF_ON:  cfg_prdata = 32'(prof_on_r);
      REG_PC_LOW:   cfg_prdata = pc_low_r;
      REG_PC_SCALE: cfg_prdata = 32'(pc_scale_r);
      REG_BKT_CNT:  cfg_prdata = 32'(bkt_cnt_r);
    endcase
  end

  // Flow control: the whole pipeline advances unless a result is stuck
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv && !clearing_r;
  assign take     = in_valid && in_ready;

  pcsh_map #(
    .BUCKETS (BUCKETS),
    .PC_BITS (PC_BITS)
  ) u_map (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .take         (take),
    .func         (in_func),
    .pc           (in_pc),
    .ticks        (in_ticks),
    .read_index   (in_read_index),
    .profiling_on (prof_on_r),
    .pc_low       (pc_low_r),
    .pc_scale     (pc_scale_r),
    .bucket_count (bkt_cnt_r),
    .c_out        (c_req)
  );

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(BUCKETS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Counter memory
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= 16'd0;
    end else if (wr_en) begin
      mem[d_addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q_r <= mem[c_req.addr[AW-1:0]];
    end
  end

  // Read-modify-write stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r      <= '0;
      fw_vld_r <= 1'b0;
    end else if (adv) begin
      d_r      <= c_req;
      fw_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_addr_r <= d_addr;
      fw_data_r <= sum;
    end
  end

  assign d_addr = d_r.addr[AW-1:0];
  assign rdata  = (fw_vld_r && (fw_addr_r == d_addr)) ? fw_data_r : mem_q_r;
  assign sum    = rdata + d_r.ticks;
  assign wr_en  = adv && d_r.vld && d_r.wr;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= d_r.status;
      out_bucket_r <= d_r.bucket;
      if (!d_r.acc) begin
        out_count_r <= 16'd0;
      end else if (d_r.wr) begin
        out_count_r <= sum;
      end else begin
        out_count_r <= rdata;
      end
    end
  end

  assign out_valid  = out_vld_r;
  assign out_status = out_status_r;
  assign out_bucket = out_bucket_r;
  assign out_count  = out_count_r;

endmodule

FILE: rtl/pcsh_map.sv
// Bucket mapping pipeline: offset, scale multiply, range check.
// Three register stages; depends on pcsh_pkg.
module pcsh_map #(
  parameter int BUCKETS = 4096,
  parameter int PC_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                take,
  input  logic                func,
  input  logic [PC_BITS-1:0]  pc,
  input  logic [15:0]         ticks,
  input  logic [11:0]         read_index,
  input  logic                profiling_on,
  input  logic [31:0]         pc_low,
  input  logic [16:0]         pc_scale,
  input  logic [12:0]         bucket_count,
  output pcsh_pkg::pipe_t     c_out
);
  import pcsh_pkg::*;

  localparam int CW = (PC_BITS > 32) ? PC_BITS : 32;
  localparam int W  = CW - 2;
  localparam int WL = (W > 32) ? 32 : W;
  localparam int PW = WL + 17;

  logic [CW:0]   diff;
  logic [W-1:0]  w;
  logic          big;

  logic          a_vld_r, a_rd_r, a_off_r, a_below_r, a_big_r;
  logic [WL-1:0] a_wlo_r;
  logic [15:0]   a_ticks_r;
  logic [11:0]   a_ridx_r;

  logic          b_vld_r, b_rd_r, b_off_r, b_below_r, b_big_r;
  logic [PW-1:0] b_prod_r;
  logic [15:0]   b_ticks_r;
  logic [11:0]   b_ridx_r;

  logic [32:0]   bidx;
  logic [16:0]   lim;
  logic [16:0]   ridx_ext;
  logic          oor;
  pipe_t         c_nxt, c_r;

  assign diff = {1'b0, CW'(pc)} - {1'b0, CW'(pc_low)};
  assign w    = diff[CW-1:2];

  generate
    if (W > WL) begin : g_big
      assign big = |w[W-1:WL];
    end else begin : g_nobig
      assign big = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_r     <= '0;
    end else if (en) begin
      a_vld_r <= take;
      b_vld_r <= a_vld_r;
      c_r     <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rd_r    <= (func == FUNC_READ);
      a_off_r   <= !profiling_on;
      a_below_r <= diff[CW];
      a_big_r   <= big;
      a_wlo_r   <= w[WL-1:0];
      a_ticks_r <= ticks;
      a_ridx_r  <= read_index;

      b_rd_r    <= a_rd_r;
      b_off_r   <= a_off_r;
      b_below_r <= a_below_r;
      b_big_r   <= a_big_r;
      b_prod_r  <= PW'(a_wlo_r) * PW'(pc_scale);
      b_ticks_r <= a_ticks_r;
      b_ridx_r  <= a_ridx_r;
    end
  end

  assign bidx     = 33'(b_prod_r[PW-1:16]);
  assign lim      = (17'(bucket_count) > 17'(BUCKETS)) ? 17'(BUCKETS) : 17'(bucket_count);
  assign ridx_ext = 17'(b_ridx_r);
  assign oor      = b_below_r || (b_big_r && (pc_scale != 17'd0)) || (bidx >= 33'(lim));

  always_comb begin
    c_nxt        = '0;
    c_nxt.vld    = b_vld_r;
    c_nxt.ticks  = b_ticks_r;
    if (b_rd_r) begin
      c_nxt.status = ST_READ;
      c_nxt.acc    = (ridx_ext < 17'(BUCKETS));
      c_nxt.addr   = 16'(b_ridx_r);
      c_nxt.bucket = b_ridx_r;
    end else if (b_off_r) begin
      c_nxt.status = ST_OFF;
    end else if (oor) begin
      c_nxt.status = ST_RANGE;
    end else begin
      c_nxt.status = ST_COUNTED;
      c_nxt.acc    = 1'b1;
      c_nxt.wr     = 1'b1;
      c_nxt.addr   = bidx[15:0];
      c_nxt.bucket = bidx[11:0];
    end
  end

  assign c_out = c_r;

endmodule
